### src/ehr_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and helper functions of the echo reply rewriter
package ehr_pkg;

  localparam int MAC_BYTES     = 6;
  localparam int ETH_HDR_BYTES = 2 * MAC_BYTES + 2;
  localparam int IP_HDR_BYTES  = 20;
  localparam int HOLD_BYTES    = ETH_HDR_BYTES + IP_HDR_BYTES + 1;
  localparam int CHECK_POS     = ETH_HDR_BYTES + 10;
  localparam int SRC_IP_POS    = ETH_HDR_BYTES + 12;
  localparam int DST_IP_POS    = ETH_HDR_BYTES + 16;
  localparam int TYPE_POS      = ETH_HDR_BYTES + IP_HDR_BYTES;
  localparam int POS_W         = $clog2(HOLD_BYTES + 1);
  localparam int HOLD_AW       = $clog2(HOLD_BYTES);
  localparam int SUM_W         = 20;
  localparam int QUEUE_DEPTH   = 4;

  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic [1:0] {
    CMD_PASS,
    CMD_HDR,
    CMD_SHORT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;
    logic        last;
    pos_t        len;
    logic [15:0] check;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_SEND
  } back_state_t;

  // hold address of the byte that goes out at position pos
  function automatic pos_t hold_addr(input pos_t pos, input logic rewrite);
    pos_t addr;
    addr = pos;
    if (rewrite) begin
      if (pos < POS_W'(MAC_BYTES)) begin
        addr = pos + POS_W'(MAC_BYTES);
      end else if (pos < POS_W'(2 * MAC_BYTES)) begin
        addr = pos - POS_W'(MAC_BYTES);
      end else if (pos >= POS_W'(SRC_IP_POS) && pos < POS_W'(SRC_IP_POS + 4)) begin
        addr = pos + POS_W'(4);
      end else if (pos >= POS_W'(DST_IP_POS) && pos < POS_W'(DST_IP_POS + 4)) begin
        addr = pos - POS_W'(4);
      end
    end
    return addr;
  endfunction

  function automatic logic [15:0] fold_checksum(input logic [SUM_W-1:0] sum);
    logic [16:0] t1;
    logic [15:0] t2;
    t1 = {1'b0, sum[15:0]} + 17'(sum[SUM_W-1:16]);
    t2 = t1[15:0] + 16'(t1[16]);
    return ~t2;
  endfunction

endpackage

### src/ehr_in_if.sv
`timescale 1ns / 1ps
// input channel carrying frame bytes
interface ehr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink (input valid, input data_byte, input frame_end, output ready);
endinterface

### src/ehr_out_if.sv
`timescale 1ns / 1ps
// output channel carrying reply bytes
interface ehr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

### src/ehr_ram.sv
`timescale 1ns / 1ps
// generic single write port ram with registered read
module ehr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 35
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### src/ehr_front.sv
`timescale 1ns / 1ps
// front end: takes frame bytes, holds the header, sums it and issues commands
module ehr_front (
  input  logic          clk,
  input  logic          rst,
  ehr_in_if.sink        rx,
  output logic          push,
  output ehr_pkg::cmd_t push_cmd,
  input  logic          q_full,
  input  logic          burst_done,
  output logic          wr_en,
  output ehr_pkg::pos_t wr_addr,
  output logic [7:0]    wr_data
);
  import ehr_pkg::*;

  pos_t             byte_position, byte_position_next;
  logic [SUM_W-1:0] header_sum, header_sum_next;
  logic             passing_through, passing_through_next;
  logic             burst_busy;
  logic             accept;
  logic             burst_push;
  pos_t             pos, pos_inc;
  logic             in_ip;

  assign rx.ready = passing_through ? !q_full : (!q_full && !burst_busy);
  assign accept   = rx.valid && rx.ready;

  assign pos     = (byte_position >= POS_W'(HOLD_BYTES)) ? '0 : byte_position;
  assign pos_inc = pos + POS_W'(1);
  assign in_ip   = pos >= POS_W'(ETH_HDR_BYTES) && pos < POS_W'(ETH_HDR_BYTES + IP_HDR_BYTES)
                   && pos != POS_W'(CHECK_POS) && pos != POS_W'(CHECK_POS + 1);

  assign wr_en   = accept && !passing_through;
  assign wr_addr = pos;
  assign wr_data = rx.data_byte;

  always_comb begin
    byte_position_next   = byte_position;
    header_sum_next      = header_sum;
    passing_through_next = passing_through;
    push                 = 1'b0;
    burst_push           = 1'b0;
    push_cmd.kind        = CMD_PASS;
    push_cmd.data        = rx.data_byte;
    push_cmd.last        = rx.frame_end;
    push_cmd.len         = pos_inc;
    push_cmd.check       = fold_checksum(header_sum);
    if (accept) begin
      if (passing_through) begin
        push = 1'b1;
        if (rx.frame_end) begin
          passing_through_next = 1'b0;
          byte_position_next   = '0;
          header_sum_next      = '0;
        end
      end else begin
        if (in_ip) begin
          // even offsets in the ip header are the high byte of a word
          if (!pos[0]) begin
            header_sum_next = header_sum + {4'b0, rx.data_byte, 8'b0};
          end else begin
            header_sum_next = header_sum + {12'b0, rx.data_byte};
          end
        end
        if (pos_inc == POS_W'(HOLD_BYTES)) begin
          push                 = 1'b1;
          burst_push           = 1'b1;
          push_cmd.kind        = CMD_HDR;
          byte_position_next   = '0;
          header_sum_next      = '0;
          passing_through_next = !rx.frame_end;
        end else if (rx.frame_end) begin
          push               = 1'b1;
          burst_push         = 1'b1;
          push_cmd.kind      = CMD_SHORT;
          push_cmd.last      = 1'b1;
          byte_position_next = '0;
          header_sum_next    = '0;
        end else begin
          byte_position_next = pos_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      header_sum      <= '0;
      passing_through <= 1'b0;
      burst_busy      <= 1'b0;
    end else begin
      byte_position   <= byte_position_next;
      header_sum      <= header_sum_next;
      passing_through <= passing_through_next;
      if (burst_push) begin
        burst_busy <= 1'b1;
      end else if (burst_done) begin
        burst_busy <= 1'b0;
      end
    end
  end

endmodule

### src/ehr_queue.sv
`timescale 1ns / 1ps
// short command queue between front and back
module ehr_queue #(
  parameter int DEPTH = ehr_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ehr_pkg::cmd_t push_cmd,
  input  logic          pop,
  output ehr_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);
  import ehr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = count == CNT_W'(DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### src/ehr_back.sv
`timescale 1ns / 1ps
// back end: replays held headers (rewritten for full headers) and forwards pass bytes
module ehr_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  ehr_pkg::cmd_t q_head,
  output logic          q_pop,
  output ehr_pkg::pos_t rd_addr,
  input  logic [7:0]    rd_data,
  output logic          burst_done,
  ehr_out_if.source     tx
);
  import ehr_pkg::*;

  back_state_t state, state_next;
  cmd_t        cur;
  pos_t        idx;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        out_free;
  logic        is_final;
  logic        load_out;
  logic [7:0]  load_byte;
  logic        load_last;
  logic        latch_cmd;
  logic        idx_inc;
  logic [7:0]  burst_byte;

  assign tx.valid    = out_valid;
  assign tx.out_byte = out_byte;
  assign tx.out_last = out_last;

  assign out_free = !out_valid || tx.ready;
  assign is_final = idx == cur.len - POS_W'(1);
  assign rd_addr  = hold_addr(idx, cur.kind == CMD_HDR);

  always_comb begin
    burst_byte = rd_data;
    if (cur.kind == CMD_HDR) begin
      if (idx == POS_W'(CHECK_POS)) begin
        burst_byte = cur.check[15:8];
      end else if (idx == POS_W'(CHECK_POS + 1)) begin
        burst_byte = cur.check[7:0];
      end else if (idx == POS_W'(TYPE_POS)) begin
        burst_byte = 8'h00;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty && q_head.kind != CMD_PASS) begin
          state_next = BK_READ;
        end
      end
      BK_READ: state_next = BK_SEND;
      BK_SEND: begin
        if (out_free) begin
          state_next = is_final ? BK_IDLE : BK_READ;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = 1'b0;
    load_out   = 1'b0;
    load_byte  = burst_byte;
    load_last  = 1'b0;
    latch_cmd  = 1'b0;
    idx_inc    = 1'b0;
    burst_done = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          if (q_head.kind == CMD_PASS) begin
            if (out_free) begin
              q_pop     = 1'b1;
              load_out  = 1'b1;
              load_byte = q_head.data;
              load_last = q_head.last;
            end
          end else begin
            q_pop     = 1'b1;
            latch_cmd = 1'b1;
          end
        end
      end
      BK_READ: begin
      end
      BK_SEND: begin
        if (out_free) begin
          load_out   = 1'b1;
          load_last  = is_final && cur.last;
          idx_inc    = !is_final;
          burst_done = is_final;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (tx.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_byte <= load_byte;
      out_last <= load_last;
    end
    if (latch_cmd) begin
      cur <= q_head;
      idx <= '0;
    end else if (idx_inc) begin
      idx <= idx + POS_W'(1);
    end
  end

endmodule

### src/echo_reply_header_rewrite.sv
`timescale 1ns / 1ps
// top level of the icmp echo reply header rewriter
// Frame bytes enter on rx one per item. The first 35 bytes (ethernet header, a
// fixed 20-byte ip header, the icmp type byte) are written into a hold ram and
// produce no output; once the type byte arrives the header is replayed on tx
// with macs and ips swapped, the icmp type cleared and the ip checksum redone.
// Each replayed byte passes the registered ram read and then the output register;
// a frame that ends early is replayed unchanged in the same way. Bytes after the
// header pass at one per cycle while tx is not stalled, through a command queue
// of QUEUE_DEPTH entries, which keeps filling while a burst drains; the first
// byte of the next frame waits until the previous burst has fully left the hold
// ram.
module echo_reply_header_rewrite #(
  parameter int QUEUE_DEPTH = ehr_pkg::QUEUE_DEPTH
) (
  input logic        clk,
  input logic        rst,
  ehr_in_if.sink     rx,
  ehr_out_if.source  tx
);
  import ehr_pkg::*;

  logic       push;
  cmd_t       push_cmd;
  logic       pop;
  cmd_t       head;
  logic       q_full;
  logic       q_empty;
  logic       burst_done;
  logic       wr_en;
  pos_t       wr_addr;
  logic [7:0] wr_data;
  pos_t       rd_addr;
  logic [7:0] rd_data;

  ehr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .push       (push),
    .push_cmd   (push_cmd),
    .q_full     (q_full),
    .burst_done (burst_done),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  ehr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  ehr_ram #(
    .WIDTH (8),
    .DEPTH (HOLD_BYTES)
  ) u_hold (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr[HOLD_AW-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_addr[HOLD_AW-1:0]),
    .rd_data (rd_data)
  );

  ehr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_head     (head),
    .q_pop      (pop),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .burst_done (burst_done),
    .tx         (tx)
  );

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench of the echo reply header rewriter
module tb_top;
  import ehr_pkg::*;

  localparam int LIMIT_CYCLES    = 400000;
  localparam int RANDOM_ITEMS    = 150;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_OFF_AFTER  = 80;
  localparam int DRAIN_CYCLES    = 100;
  localparam int DIR_ROWS        = 12;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } reply_t;

  typedef struct packed {
    logic [7:0] data;
    logic       fend;
    logic       typed;
    reply_t     want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ehr_in_if  rx ();
  ehr_out_if tx ();

  echo_reply_header_rewrite u_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx),
    .tx  (tx)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [7:0]       hdr_copy [HOLD_BYTES];
  int               hdr_count  = 0;
  logic [SUM_W-1:0] ip_sum     = '0;
  bit               in_payload = 1'b0;

  reply_t reply_q [$];
  int     errors       = 0;
  int     replies_seen = 0;
  bit     held_off     = 1'b0;
  bit     rx_calm      = 1'b0;
  bit     tx_calm      = 1'b0;

  // short frames of one byte are typed in, the rest goes through the predictor
  stim_row_t dir_rows [DIR_ROWS] = '{
    '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b1}},
    '{8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1}},
    '{8'h55, 1'b1, 1'b1, '{8'h55, 1'b1}},
    '{8'hAA, 1'b1, 1'b1, '{8'hAA, 1'b1}},
    '{8'h01, 1'b0, 1'b0, '{8'h00, 1'b0}},
    '{8'h80, 1'b0, 1'b0, '{8'h00, 1'b0}},
    '{8'h7F, 1'b1, 1'b0, '{8'h00, 1'b0}},
    '{8'hFE, 1'b0, 1'b0, '{8'h00, 1'b0}},
    '{8'h00, 1'b1, 1'b0, '{8'h00, 1'b0}},
    '{8'h80, 1'b1, 1'b1, '{8'h80, 1'b1}},
    '{8'h0F, 1'b1, 1'b1, '{8'h0F, 1'b1}},
    '{8'hF0, 1'b1, 1'b1, '{8'hF0, 1'b1}}
  };

  function automatic int draw_gap(inout bit calm);
    if ($urandom_range(0, 19) == 0) begin
      calm = !calm;
    end
    return calm ? 0 : int'($urandom_range(0, 10));
  endfunction

  function automatic logic [15:0] ip_checksum(input logic [SUM_W-1:0] s);
    logic [31:0] acc;
    acc = 32'(s);
    while (acc[31:16] != 16'd0) begin
      acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
    end
    return ~acc[15:0];
  endfunction

  function automatic logic [7:0] reply_header_byte(input int p, input logic [15:0] chk);
    if (p < MAC_BYTES) return hdr_copy[p + MAC_BYTES];
    if (p < 2 * MAC_BYTES) return hdr_copy[p - MAC_BYTES];
    if (p == CHECK_POS) return chk[15:8];
    if (p == CHECK_POS + 1) return chk[7:0];
    if (p >= SRC_IP_POS && p < SRC_IP_POS + 4) return hdr_copy[p + 4];
    if (p >= DST_IP_POS && p < DST_IP_POS + 4) return hdr_copy[p - 4];
    if (p == TYPE_POS) return 8'h00;
    return hdr_copy[p];
  endfunction

  function automatic void predict_reply(input logic [7:0] d, input logic e, ref reply_t res [$]);
    int          off;
    logic [15:0] chk;
    res = {};
    if (in_payload) begin
      res.push_back('{d, e});
      if (e) begin
        in_payload = 1'b0;
      end
      return;
    end
    hdr_copy[hdr_count] = d;
    off = hdr_count - ETH_HDR_BYTES;
    if (off >= 0 && off < IP_HDR_BYTES && hdr_count != CHECK_POS &&
        hdr_count != CHECK_POS + 1) begin
      ip_sum = ip_sum + SUM_W'((off % 2 == 0) ? {d, 8'h00} : {8'h00, d});
    end
    hdr_count++;
    if (hdr_count == HOLD_BYTES) begin
      chk = ip_checksum(ip_sum);
      for (int i = 0; i < HOLD_BYTES; i++) begin
        res.push_back('{reply_header_byte(i, chk), (i == HOLD_BYTES - 1) ? e : 1'b0});
      end
      hdr_count  = 0;
      ip_sum     = '0;
      in_payload = !e;
    end else if (e) begin
      for (int i = 0; i < hdr_count; i++) begin
        res.push_back('{hdr_copy[i], (i == hdr_count - 1) ? 1'b1 : 1'b0});
      end
      hdr_count = 0;
      ip_sum    = '0;
    end
  endfunction

  task automatic send_byte(input logic [7:0] d, input logic e, input logic typed,
                           input reply_t want);
    int     gap;
    reply_t res [$];
    gap = draw_gap(rx_calm);
    if (gap > 0) begin
      rx.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx.valid     <= 1'b1;
    rx.data_byte <= d;
    rx.frame_end <= e;
    do @(posedge clk); while (!rx.ready);
    predict_reply(d, e, res);
    if (typed) begin
      reply_q.push_back(want);
    end else begin
      foreach (res[i]) reply_q.push_back(res[i]);
    end
  endtask

  // reply side: random stalls, one long hold-off
  initial begin
    int gap;
    tx.ready <= 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      gap = draw_gap(tx_calm);
      if (!held_off && replies_seen >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        gap      = HOLD_OFF_CYCLES;
      end
      if (gap > 0) begin
        tx.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      tx.ready <= 1'b1;
      do @(posedge clk); while (!tx.valid);
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (!rst && tx.valid && tx.ready) begin
      if (reply_q.size() == 0) begin
        $display("%0t: unexpected reply item byte %02h last %0b", $time, tx.out_byte,
                 tx.out_last);
        errors++;
      end else begin
        want = reply_q.pop_front();
        if (tx.out_byte !== want.data) begin
          $display("%0t: reply item %0d out_byte expected %02h got %02h", $time,
                   replies_seen, want.data, tx.out_byte);
          errors++;
        end
        if (tx.out_last !== want.last) begin
          $display("%0t: reply item %0d out_last expected %0b got %0b", $time,
                   replies_seen, want.last, tx.out_last);
          errors++;
        end
      end
      replies_seen++;
    end
  end

  initial begin
    int cycles;
    for (cycles = 0; cycles < LIMIT_CYCLES; cycles++) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int         sent;
    int         frame_no;
    int         flen;
    int         pick;
    int         style;
    logic [7:0] b;
    sent     = 0;
    frame_no = 0;
    rx.valid     <= 1'b0;
    rx.data_byte <= 8'h00;
    rx.frame_end <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].data, dir_rows[i].fend, dir_rows[i].typed, dir_rows[i].want);
    end

    // random frames: mostly full headers, some short and broken frames
    while (sent < RANDOM_ITEMS) begin
      if (frame_no == 0) begin
        flen = HOLD_BYTES;
      end else if (frame_no == 1) begin
        flen = HOLD_BYTES + 5;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
          flen = $urandom_range(1, HOLD_BYTES - 1);
        end else if (pick < 45) begin
          flen = HOLD_BYTES;
        end else begin
          flen = $urandom_range(HOLD_BYTES + 1, HOLD_BYTES + 16);
        end
      end
      style = $urandom_range(0, 9);
      for (int k = 0; k < flen; k++) begin
        if (style == 0) begin
          b = 8'hFF;
        end else if (style == 1) begin
          b = 8'h00;
        end else begin
          b = 8'($urandom);
        end
        send_byte(b, (k == flen - 1) ? 1'b1 : 1'b0, 1'b0, '0);
        sent++;
      end
      frame_no++;
    end
    rx.valid <= 1'b0;

    while (reply_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && reply_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
